FILE: rtl/cnn_pkg.sv
// ----------------------------------------------------------------------------
// cnn_pkg
// shared widths, command codes and status types for the cosine
// nearest-neighbor search unit
// ----------------------------------------------------------------------------
package cnn_pkg;

  localparam int VAL_W     = 16;   // feature element
  localparam int IDX_W     = 10;   // reported row index
  localparam int ACC_W     = 48;   // dot and squared-norm accumulators
  localparam int MX_W      = 2 * ACC_W;   // multiplicand of the serial multiplier
  localparam int PROD_W    = 3 * ACC_W;   // triple product width
  localparam int MUL_STEPS = ACC_W;       // one multiplier bit per cycle
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  // command codes of an input beat
  localparam logic CMD_PROBE   = 1'b0;
  localparam logic CMD_GALLERY = 1'b1;

  // saturation limits
  localparam logic signed [ACC_W-1:0] DOT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DOT_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic        [ACC_W-1:0] SQ_MAX  = {ACC_W{1'b1}};

  // serial multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

FILE: rtl/cnn_ram.sv
// ----------------------------------------------------------------------------
// cnn_ram
// generic single-clock ram, one write port and one read port,
// read data registered
// ----------------------------------------------------------------------------
module cnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cnn_mul.sv
// ----------------------------------------------------------------------------
// cnn_mul
// shift-add serial multiplier, one multiplier bit per cycle,
// unsigned product held until the next start
// ----------------------------------------------------------------------------
module cnn_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cnn_pkg::MX_W-1:0]   x,
  input  logic [cnn_pkg::ACC_W-1:0]  y,
  output logic [cnn_pkg::PROD_W-1:0] product,
  output cnn_pkg::mul_stat_t         stat
);

  logic [cnn_pkg::PROD_W-1:0]    x_r;
  logic [cnn_pkg::ACC_W-1:0]     y_r;
  logic [cnn_pkg::PROD_W-1:0]    acc_r;
  logic [cnn_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        x_r    <= cnn_pkg::PROD_W'(x);
        y_r    <= y;
        acc_r  <= '0;
        cnt_r  <= cnn_pkg::MUL_CNT_W'(cnn_pkg::MUL_STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
        x_r   <= x_r << 1;
        y_r   <= y_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cnn_pkg::MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/cosine_nearest_neighbour_unit.sv
// ----------------------------------------------------------------------------
// cosine_nearest_neighbour_unit
// streaming cosine nearest-neighbor search: stores a probe vector, then
// scores gallery rows by |cos| against it and reports the best row index
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  command, value, last_in_vector,
//                                         last_gallery
//  out_     output     out_valid/out_stall best_index
//
// a probe beat is written straight into the probe ram without stalling the input
// a gallery beat passes through a ram read, 16x16 products and a saturating add
// the end of a row passes through decide and close; for rows after the first
// the exact compare dot_c^2*sq_b > dot_b^2*sq_c runs as four passes
// (48 shift-add steps and a handoff each) of one multiplier;
// the first row and rows past MAX_ROWS skip it
// reset is synchronous; the probe ram is not cleared,
// entries are only used after they are written
// in_stall is high whenever an item is in flight; a result waiting under
// out_stall does not block the input unless a second result is ready
//
module cosine_nearest_neighbour_unit #(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic signed [cnn_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last_in_vector,
  input  logic                              in_last_gallery,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [cnn_pkg::IDX_W-1:0]  out_best_index
);

  // position counter can hold MAX_LEN itself (saturation point)
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [POS_W-1:0] LEN_LIM = POS_W'(MAX_LEN);
  localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(MAX_ROWS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_DECIDE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_CLOSE
  } state_t;

  state_t state_r;

  // element bookkeeping
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] plen_r;
  logic             gal_open_r;

  // current beat
  logic signed [cnn_pkg::VAL_W-1:0] val_r;
  logic                             pvalid_r;
  logic                             lv_r;
  logic                             lg_r;

  // products and accumulators
  logic signed [2*cnn_pkg::VAL_W-1:0] pv_r;
  logic        [2*cnn_pkg::VAL_W-2:0] vv_r;
  logic signed [cnn_pkg::ACC_W-1:0]   row_dot_r;
  logic        [cnn_pkg::ACC_W-1:0]   row_sq_r;
  logic        [ROW_W-1:0]            row_num_r;
  logic signed [cnn_pkg::ACC_W-1:0]   best_dot_r;
  logic        [cnn_pkg::ACC_W-1:0]   best_sq_r;
  logic        [ROW_W-1:0]            best_row_r;
  logic        [cnn_pkg::PROD_W-1:0]  lhs_r;

  // output register
  logic                      out_valid_r;
  logic [cnn_pkg::IDX_W-1:0] out_idx_r;

  // ram and multiplier hookup
  logic                             ram_we;
  logic                             ram_re;
  logic [AW-1:0]                    ram_waddr;
  logic [AW-1:0]                    ram_raddr;
  logic [cnn_pkg::VAL_W-1:0]        ram_rdata;
  logic                             mul_start;
  logic [cnn_pkg::MX_W-1:0]         mul_x;
  logic [cnn_pkg::ACC_W-1:0]        mul_y;
  logic [cnn_pkg::PROD_W-1:0]       mul_prod;
  cnn_pkg::mul_stat_t               mul_stat;

  // combinational helpers
  logic                             in_acc;
  logic                             is_probe;
  logic [POS_W-1:0]                 probe_pos;
  logic [POS_W-1:0]                 gal_pos;
  logic signed [cnn_pkg::VAL_W-1:0] p_s;
  logic signed [2*cnn_pkg::VAL_W-1:0] sq_full;
  logic signed [cnn_pkg::ACC_W:0]   dot_sum;
  logic        [cnn_pkg::ACC_W:0]   sq_sum;
  logic signed [cnn_pkg::ACC_W-1:0] dot_sat;
  logic        [cnn_pkg::ACC_W-1:0] sq_sat;
  logic        [cnn_pkg::ACC_W-1:0] row_mag;
  logic        [cnn_pkg::ACC_W-1:0] best_mag;
  logic                             out_block;
  logic                             out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_probe = (in_command == cnn_pkg::CMD_PROBE);

  // a probe after a partial gallery row restarts at element zero, and so
  // does a gallery row after a partial probe
  assign probe_pos = gal_open_r ? '0 : pos_r;
  assign gal_pos   = gal_open_r ? pos_r : '0;

  assign ram_we    = in_acc && is_probe && (probe_pos < LEN_LIM);
  assign ram_waddr = AW'(probe_pos);
  assign ram_re    = in_acc && !is_probe;
  assign ram_raddr = AW'(gal_pos);

  // read and write never meet in one cycle: one item at a time
  cnn_ram #(
    .WIDTH (cnn_pkg::VAL_W),
    .DEPTH (MAX_LEN)
  ) u_probe_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // products for the mac stage; probe past its length counts as zero
  assign p_s     = pvalid_r ? $signed(ram_rdata) : '0;
  assign sq_full = val_r * val_r;

  // saturating accumulate
  always_comb begin
    dot_sum = {row_dot_r[cnn_pkg::ACC_W-1], row_dot_r}
            + (cnn_pkg::ACC_W+1)'(pv_r);
    sq_sum  = {1'b0, row_sq_r} + (cnn_pkg::ACC_W+1)'(vv_r);
    if (dot_sum[cnn_pkg::ACC_W] != dot_sum[cnn_pkg::ACC_W-1]) begin
      dot_sat = dot_sum[cnn_pkg::ACC_W] ? cnn_pkg::DOT_MIN : cnn_pkg::DOT_MAX;
    end else begin
      dot_sat = dot_sum[cnn_pkg::ACC_W-1:0];
    end
    sq_sat = sq_sum[cnn_pkg::ACC_W] ? cnn_pkg::SQ_MAX : sq_sum[cnn_pkg::ACC_W-1:0];
  end

  // magnitudes; the most negative dot still fits unsigned
  assign row_mag  = row_dot_r[cnn_pkg::ACC_W-1] ? (~row_dot_r + 1'b1) : row_dot_r;
  assign best_mag = best_dot_r[cnn_pkg::ACC_W-1] ? (~best_dot_r + 1'b1) : best_dot_r;

  // compare passes: lhs = |dot_c|^2 * sq_b, rhs = |dot_b|^2 * sq_c
  always_comb begin
    mul_start = 1'b0;
    mul_x     = cnn_pkg::MX_W'(row_mag);
    mul_y     = row_mag;
    unique case (state_r)
      ST_DECIDE: begin
        mul_start = (row_num_r < ROW_LIM) && (row_num_r != '0);
      end
      ST_M1: begin
        mul_start = mul_stat.done;
        mul_x     = mul_prod[cnn_pkg::MX_W-1:0];
        mul_y     = best_sq_r;
      end
      ST_M2: begin
        mul_start = mul_stat.done;
        mul_x     = cnn_pkg::MX_W'(best_mag);
        mul_y     = best_mag;
      end
      ST_M3: begin
        mul_start = mul_stat.done;
        mul_x     = mul_prod[cnn_pkg::MX_W-1:0];
        mul_y     = row_sq_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  cnn_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  // a second result waits while the first is still stalled
  assign out_block = out_valid_r && out_stall;
  // a new result enters the output register this cycle
  assign out_load  = (state_r == ST_CLOSE) && lg_r && !out_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      plen_r      <= '0;
      gal_open_r  <= 1'b0;
      row_dot_r   <= '0;
      row_sq_r    <= '0;
      row_num_r   <= '0;
      best_dot_r  <= '0;
      best_sq_r   <= '0;
      best_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && is_probe) begin
            // probe beat: store, count, clear any search in progress
            gal_open_r <= 1'b0;
            row_dot_r  <= '0;
            row_sq_r   <= '0;
            row_num_r  <= '0;
            best_dot_r <= '0;
            best_sq_r  <= '0;
            best_row_r <= '0;
            if (in_last_in_vector) begin
              plen_r <= (probe_pos < LEN_LIM) ? probe_pos + 1'b1 : LEN_LIM;
              pos_r  <= '0;
            end else if (probe_pos < LEN_LIM) begin
              pos_r <= probe_pos + 1'b1;
            end else begin
              pos_r <= probe_pos;
            end
          end else if (in_acc) begin
            // gallery beat: ram read issued this cycle
            gal_open_r <= 1'b1;
            pos_r      <= gal_pos;
            pvalid_r   <= (gal_pos < plen_r);
            val_r      <= in_value;
            lv_r       <= in_last_in_vector;
            lg_r       <= in_last_gallery;
            state_r    <= ST_MAC;
          end
        end

        ST_MAC: begin
          pv_r <= p_s * val_r;
          vv_r <= sq_full[2*cnn_pkg::VAL_W-2:0];
          if (pos_r < LEN_LIM) begin
            pos_r <= pos_r + 1'b1;
          end
          state_r <= ST_ACC;
        end

        ST_ACC: begin
          row_dot_r <= dot_sat;
          row_sq_r  <= sq_sat;
          state_r   <= (lv_r || lg_r) ? ST_DECIDE : ST_IDLE;
        end

        ST_DECIDE: begin
          if (row_num_r >= ROW_LIM) begin
            state_r <= ST_CLOSE;
          end else if (row_num_r == '0) begin
            // first row of a search always becomes the best
            best_dot_r <= row_dot_r;
            best_sq_r  <= row_sq_r;
            best_row_r <= row_num_r;
            row_num_r  <= row_num_r + 1'b1;
            state_r    <= ST_CLOSE;
          end else begin
            state_r <= ST_M1;
          end
        end

        ST_M1: begin
          if (mul_stat.done) begin
            state_r <= ST_M2;
          end
        end

        ST_M2: begin
          if (mul_stat.done) begin
            lhs_r   <= mul_prod;
            state_r <= ST_M3;
          end
        end

        ST_M3: begin
          if (mul_stat.done) begin
            state_r <= ST_M4;
          end
        end

        ST_M4: begin
          if (mul_stat.done) begin
            // strict compare: ties keep the earlier row, zero norm never wins
            if (lhs_r > mul_prod) begin
              best_dot_r <= row_dot_r;
              best_sq_r  <= row_sq_r;
              best_row_r <= row_num_r;
            end
            row_num_r <= row_num_r + 1'b1;
            state_r   <= ST_CLOSE;
          end
        end

        ST_CLOSE: begin
          if (!(lg_r && out_block)) begin
            row_dot_r  <= '0;
            row_sq_r   <= '0;
            pos_r      <= '0;
            gal_open_r <= 1'b0;
            if (lg_r) begin
              out_valid_r <= 1'b1;
              out_idx_r   <= cnn_pkg::IDX_W'(best_row_r);
              row_num_r   <= '0;
              best_dot_r  <= '0;
              best_sq_r   <= '0;
              best_row_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_idx_r;

endmodule

FILE: rtl/cnn_chk.sv
// ----------------------------------------------------------------------------
// cnn_chk
// port-level checks for the cosine nearest-neighbor search unit,
// bound to the top level
// ----------------------------------------------------------------------------
module cnn_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_command,
  input logic signed [cnn_pkg::VAL_W-1:0] in_value,
  input logic                             in_last_in_vector,
  input logic                             in_last_gallery,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic        [cnn_pkg::IDX_W-1:0] out_best_index
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_index))
    else $error("stalled result changed");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a gallery beat keeps the input stalled while its mac runs
  a_gallery_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_command == cnn_pkg::CMD_GALLERY) |=> in_stall)
    else $error("gallery beat did not stall the input");

  // a probe beat never produces a result
  a_probe_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_command == cnn_pkg::CMD_PROBE) |=> !$rose(out_valid))
    else $error("result raised by a probe beat");

  // a result only follows a beat marked as the last of the gallery
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_command == cnn_pkg::CMD_GALLERY) && !in_last_gallery
      |=> !$rose(out_valid))
    else $error("result raised by an ordinary gallery beat");

endmodule

bind cosine_nearest_neighbour_unit cnn_chk u_cnn_chk (.*);
